>>> rtl/core/sdbt_pkg.sv
`timescale 1ns / 1ps

package sdbt_pkg;

	// Block geometry and field widths.
	localparam int BlockBytes = 512;
	localparam int BlockShift = $clog2(BlockBytes);
	localparam int SectorW    = 23;
	localparam int TickW      = 16;
	localparam int IdxW       = 10;
	localparam int ByteW      = 8;
	localparam int StatusW    = 3;
	localparam int CmdW       = 2;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 23;
	localparam int AddrW      = SectorW + BlockShift;

	// Bytes on the wire.
	localparam logic [ByteW-1:0] FillByte   = 8'hFF;
	localparam logic [ByteW-1:0] StartToken = 8'hFE;
	localparam logic [ByteW-1:0] CmdCrc     = 8'h01;
	localparam logic [ByteW-1:0] CmdBase    = 8'h40;
	localparam logic [ByteW-1:0] RespMask   = 8'h1F;
	localparam logic [ByteW-1:0] RespAccept = 8'h05;
	localparam logic [ByteW-1:0] R1Busy     = 8'h80;
	localparam logic [ByteW-1:0] CmdIdxRead  = 8'd17;
	localparam logic [ByteW-1:0] CmdIdxWrite = 8'd24;

	// Register reset values.
	localparam logic [TickW-1:0] RespTimeoutRst  = 16'd5;
	localparam logic [TickW-1:0] TokenTimeoutRst = 16'd100;
	localparam logic [TickW-1:0] BusyTimeoutRst  = 16'd500;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FRAME,
		PH_R1,
		PH_TOKEN,
		PH_DATA,
		PH_PAYLOAD,
		PH_WRESP,
		PH_BUSY
	} phase_t;

	typedef enum logic [CmdW-1:0] {
		CMD_READ,
		CMD_WRITE,
		CMD_XCHG,
		CMD_TICK
	} cmd_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK,
		ST_ERROR,
		ST_PARAM,
		ST_REJECT,
		ST_BUSY
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MAX_SECTOR,
		REG_RESP_TIMEOUT,
		REG_TOKEN_TIMEOUT,
		REG_BUSY_TIMEOUT
	} reg_t;

	typedef struct packed {
		logic [SectorW-1:0] max_sector;
		logic [TickW-1:0]   resp_timeout;
		logic [TickW-1:0]   token_timeout;
		logic [TickW-1:0]   busy_timeout;
	} cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic               is_write;
		logic [IdxW-1:0]    byte_index;
		logic [TickW-1:0]   tick_count;
		logic [SectorW-1:0] sector;
		logic [IdxW-1:0]    offset;
		logic [IdxW-1:0]    count;
		logic               selected;
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [SectorW-1:0] sector;
		logic [IdxW-1:0]    offset;
		logic [IdxW-1:0]    count;
		logic [ByteW-1:0]   rx_byte;
		logic [ByteW-1:0]   tx_data;
	} item_t;

	typedef struct packed {
		logic [ByteW-1:0] tx_byte;
		logic             tx_valid;
		logic             card_select;
		logic [ByteW-1:0] rd_data;
		logic             rd_valid;
		logic             take_payload;
		logic             done_res;
		status_t          status;
	} res_t;

endpackage

>>> rtl/core/sdbt_if.sv
`timescale 1ns / 1ps

// Input channel: one request, byte exchange or timer tick per item.
interface sdbt_in_if;
	logic                          valid;
	logic                          ready;
	logic [sdbt_pkg::CmdW-1:0]     cmd;
	logic [sdbt_pkg::SectorW-1:0]  sector;
	logic [sdbt_pkg::IdxW-1:0]     offset;
	logic [sdbt_pkg::IdxW-1:0]     count;
	logic [sdbt_pkg::ByteW-1:0]    rx_byte;
	logic [sdbt_pkg::ByteW-1:0]    tx_data;

	modport source (output valid, cmd, sector, offset, count, rx_byte, tx_data, input ready);
	modport sink   (input valid, cmd, sector, offset, count, rx_byte, tx_data, output ready);
endinterface

// Output channel: one result item for every input item.
interface sdbt_out_if;
	logic                          valid;
	logic                          ready;
	logic [sdbt_pkg::ByteW-1:0]    tx_byte;
	logic                          tx_valid;
	logic                          card_select;
	logic [sdbt_pkg::ByteW-1:0]    rd_data;
	logic                          rd_valid;
	logic                          take_payload;
	logic                          done_res;
	logic [sdbt_pkg::StatusW-1:0]  status;

	modport source (output valid, tx_byte, tx_valid, card_select, rd_data, rd_valid,
		take_payload, done_res, status, input ready);
	modport sink   (input valid, tx_byte, tx_valid, card_select, rd_data, rd_valid,
		take_payload, done_res, status, output ready);
endinterface

>>> rtl/core/sdbt_step.sv
`timescale 1ns / 1ps

// Transaction sequencer step: given the current state, the registers and one
// item, produce the next state and the result item.
module sdbt_step (
	input  sdbt_pkg::state_t st,
	input  sdbt_pkg::cfg_t   cfg,
	input  sdbt_pkg::item_t  item,
	output sdbt_pkg::state_t nxt,
	output sdbt_pkg::res_t   res
);

	logic                          finish;
	sdbt_pkg::status_t             fin_status;
	logic                          issue;
	logic [sdbt_pkg::ByteW-1:0]    issue_byte;
	logic [sdbt_pkg::TickW-1:0]    tick_inc;
	logic [sdbt_pkg::TickW-1:0]    tick_limit;
	logic                          timed_wait;
	logic [sdbt_pkg::IdxW-1:0]     idx_inc;
	logic [sdbt_pkg::IdxW:0]       win_end;
	logic [sdbt_pkg::AddrW-1:0]    address;
	logic [sdbt_pkg::ByteW-1:0]    frame_byte;

	// Saturating tick counter and the limit of the wait in progress.
	assign tick_inc = (st.tick_count == '1) ? st.tick_count : st.tick_count + 1'b1;
	assign idx_inc  = st.byte_index + 1'b1;
	assign win_end  = {1'b0, st.offset} + {1'b0, st.count};
	assign address  = {st.sector, {sdbt_pkg::BlockShift{1'b0}}};

	always_comb begin
		timed_wait = 1'b1;
		tick_limit = cfg.resp_timeout;
		case (st.phase)
			sdbt_pkg::PH_R1:    tick_limit = cfg.resp_timeout;
			sdbt_pkg::PH_TOKEN: tick_limit = cfg.token_timeout;
			sdbt_pkg::PH_BUSY:  tick_limit = cfg.busy_timeout;
			default:            timed_wait = 1'b0;
		endcase
	end

	// Command frame byte at the position that follows the current one.
	always_comb begin
		case (idx_inc[2:0])
			3'd0, 3'd1: frame_byte = sdbt_pkg::FillByte;
			3'd2: frame_byte = sdbt_pkg::CmdBase |
				(st.is_write ? sdbt_pkg::CmdIdxWrite : sdbt_pkg::CmdIdxRead);
			3'd3: frame_byte = address[31:24];
			3'd4: frame_byte = address[23:16];
			3'd5: frame_byte = address[15:8];
			3'd6: frame_byte = address[7:0];
			default: frame_byte = sdbt_pkg::CmdCrc;
		endcase
	end

	// Phase sequencing for one item.
	always_comb begin
		nxt        = st;
		res        = '0;
		res.status = sdbt_pkg::ST_OK;
		finish     = 1'b0;
		fin_status = sdbt_pkg::ST_OK;
		issue      = 1'b0;
		issue_byte = sdbt_pkg::FillByte;

		case (item.cmd)
			sdbt_pkg::CMD_READ, sdbt_pkg::CMD_WRITE: begin
				if (st.phase == sdbt_pkg::PH_IDLE) begin
					nxt.is_write = (item.cmd == sdbt_pkg::CMD_WRITE);
					if (item.sector > cfg.max_sector ||
						(item.cmd == sdbt_pkg::CMD_READ && item.count == '0)) begin
						finish     = 1'b1;
						fin_status = sdbt_pkg::ST_PARAM;
					end else begin
						nxt.sector     = item.sector;
						nxt.offset     = item.offset;
						nxt.count      = item.count;
						nxt.byte_index = '0;
						nxt.tick_count = '0;
						nxt.phase      = sdbt_pkg::PH_FRAME;
						nxt.selected   = 1'b0;
						issue          = 1'b1;
					end
				end
			end
			sdbt_pkg::CMD_TICK: begin
				if (timed_wait) begin
					nxt.tick_count = tick_inc;
					if (tick_inc >= tick_limit) begin
						finish     = 1'b1;
						fin_status = (st.phase == sdbt_pkg::PH_BUSY) ?
							sdbt_pkg::ST_BUSY : sdbt_pkg::ST_ERROR;
					end
				end
			end
			default: begin
				case (st.phase)
					sdbt_pkg::PH_FRAME: begin
						nxt.byte_index = idx_inc;
						nxt.selected   = 1'b1;
						issue          = 1'b1;
						if (idx_inc <= sdbt_pkg::IdxW'(7)) begin
							issue_byte = frame_byte;
						end else begin
							nxt.phase      = sdbt_pkg::PH_R1;
							nxt.tick_count = '0;
						end
					end
					sdbt_pkg::PH_R1: begin
						if ((item.rx_byte & sdbt_pkg::R1Busy) != '0) begin
							issue = 1'b1;
						end else if (item.rx_byte != '0) begin
							finish     = 1'b1;
							fin_status = sdbt_pkg::ST_ERROR;
						end else if (st.is_write) begin
							nxt.phase      = sdbt_pkg::PH_PAYLOAD;
							nxt.byte_index = '0;
							issue          = 1'b1;
							issue_byte     = sdbt_pkg::StartToken;
						end else begin
							nxt.phase      = sdbt_pkg::PH_TOKEN;
							nxt.tick_count = '0;
							issue          = 1'b1;
						end
					end
					sdbt_pkg::PH_TOKEN: begin
						if (item.rx_byte == sdbt_pkg::FillByte) begin
							issue = 1'b1;
						end else if (item.rx_byte == sdbt_pkg::StartToken) begin
							nxt.phase      = sdbt_pkg::PH_DATA;
							nxt.byte_index = '0;
							issue          = 1'b1;
						end else begin
							finish     = 1'b1;
							fin_status = sdbt_pkg::ST_ERROR;
						end
					end
					sdbt_pkg::PH_DATA: begin
						// Deliver only bytes inside the requested window.
						if (st.byte_index >= st.offset && {1'b0, st.byte_index} < win_end) begin
							res.rd_data  = item.rx_byte;
							res.rd_valid = 1'b1;
						end
						nxt.byte_index = idx_inc;
						if (idx_inc >= sdbt_pkg::IdxW'(sdbt_pkg::BlockBytes + 2)) begin
							finish     = 1'b1;
							fin_status = sdbt_pkg::ST_OK;
						end else begin
							issue = 1'b1;
						end
					end
					sdbt_pkg::PH_PAYLOAD: begin
						issue = 1'b1;
						if (st.byte_index < sdbt_pkg::IdxW'(sdbt_pkg::BlockBytes)) begin
							issue_byte       = item.tx_data;
							res.take_payload = 1'b1;
							nxt.byte_index   = idx_inc;
						end else if (st.byte_index <
							sdbt_pkg::IdxW'(sdbt_pkg::BlockBytes + 2)) begin
							nxt.byte_index = idx_inc;
						end else begin
							nxt.phase = sdbt_pkg::PH_WRESP;
						end
					end
					sdbt_pkg::PH_WRESP: begin
						if ((item.rx_byte & sdbt_pkg::RespMask) != sdbt_pkg::RespAccept) begin
							finish     = 1'b1;
							fin_status = sdbt_pkg::ST_REJECT;
						end else begin
							nxt.phase      = sdbt_pkg::PH_BUSY;
							nxt.tick_count = '0;
							issue          = 1'b1;
						end
					end
					sdbt_pkg::PH_BUSY: begin
						if (item.rx_byte != '0) begin
							finish     = 1'b1;
							fin_status = sdbt_pkg::ST_OK;
						end else begin
							issue = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		endcase

		// Every ending item returns to idle and deselects the card.
		if (finish) begin
			nxt.phase    = sdbt_pkg::PH_IDLE;
			nxt.selected = 1'b0;
			res.done_res = 1'b1;
			res.status   = fin_status;
		end
		if (issue) begin
			res.tx_byte  = issue_byte;
			res.tx_valid = 1'b1;
		end
		res.card_select = nxt.selected;
	end

endmodule

>>> rtl/core/sd_spi_block_transfer.sv
`timescale 1ns / 1ps

// SPI-mode SD host engine for one single-block read or write. Each input item
// is a start request, one completed SPI byte exchange or one timer tick, and it
// yields exactly one result item telling the SPI side which byte to send next,
// the chip select level, any delivered read byte and, on the last item of a
// transaction, its status. An item is taken every clock cycle unless the output
// handshake stalls: the sequencer step is evaluated as the item is accepted and
// its result is captured in an output register, so throughput is one item per
// cycle while the output is ready. The user must write registers through the cfg
// port only while no transaction is in progress; the block does not enforce it.
module sd_spi_block_transfer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sdbt_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [sdbt_pkg::CfgDataW-1:0]   cfg_data,
	sdbt_in_if.sink                         in_ch,
	sdbt_out_if.source                      out_ch
);

	sdbt_pkg::cfg_t   cfg_q;
	sdbt_pkg::state_t state_q;
	sdbt_pkg::state_t state_nxt;
	sdbt_pkg::item_t  item;
	sdbt_pkg::res_t   res;
	sdbt_pkg::res_t   res_q;
	logic             res_valid_q;
	logic             in_fire;

	// Accept while the result register is empty or being drained.
	assign in_ch.ready = !res_valid_q || out_ch.ready;
	assign in_fire     = in_ch.valid && in_ch.ready;

	assign item.cmd     = sdbt_pkg::cmd_t'(in_ch.cmd);
	assign item.sector  = in_ch.sector;
	assign item.offset  = in_ch.offset;
	assign item.count   = in_ch.count;
	assign item.rx_byte = in_ch.rx_byte;
	assign item.tx_data = in_ch.tx_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_sector    <= '0;
			cfg_q.resp_timeout  <= sdbt_pkg::RespTimeoutRst;
			cfg_q.token_timeout <= sdbt_pkg::TokenTimeoutRst;
			cfg_q.busy_timeout  <= sdbt_pkg::BusyTimeoutRst;
		end else if (cfg_we) begin
			case (sdbt_pkg::reg_t'(cfg_index))
				sdbt_pkg::REG_MAX_SECTOR:    cfg_q.max_sector    <= cfg_data;
				sdbt_pkg::REG_RESP_TIMEOUT:  cfg_q.resp_timeout  <= cfg_data[sdbt_pkg::TickW-1:0];
				sdbt_pkg::REG_TOKEN_TIMEOUT: cfg_q.token_timeout <= cfg_data[sdbt_pkg::TickW-1:0];
				sdbt_pkg::REG_BUSY_TIMEOUT:  cfg_q.busy_timeout  <= cfg_data[sdbt_pkg::TickW-1:0];
				default: begin
				end
			endcase
		end
	end

	sdbt_step u_step (
		.st  (state_q),
		.cfg (cfg_q),
		.item(item),
		.nxt (state_nxt),
		.res (res)
	);

	// Transaction state advances once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= sdbt_pkg::PH_IDLE;
			state_q.is_write   <= 1'b0;
			state_q.byte_index <= '0;
			state_q.tick_count <= '0;
			state_q.sector     <= '0;
			state_q.offset     <= '0;
			state_q.count      <= '0;
			state_q.selected   <= 1'b0;
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_fire) begin
			res_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res;
		end
	end

	assign out_ch.valid        = res_valid_q;
	assign out_ch.tx_byte      = res_q.tx_byte;
	assign out_ch.tx_valid     = res_q.tx_valid;
	assign out_ch.card_select  = res_q.card_select;
	assign out_ch.rd_data      = res_q.rd_data;
	assign out_ch.rd_valid     = res_q.rd_valid;
	assign out_ch.take_payload = res_q.take_payload;
	assign out_ch.done_res     = res_q.done_res;
	assign out_ch.status       = res_q.status;

`ifndef NO_ASSERTIONS
	// An ending item leaves the sequencer idle with the card deselected.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res.done_res |=> state_q.phase == sdbt_pkg::PH_IDLE && !state_q.selected)
		else $error("transaction end did not return to idle");

	// A status other than ok only travels with a done flag.
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.done_res |-> res_q.status == sdbt_pkg::ST_OK)
		else $error("status reported without done");

	// A delivered read byte is only produced while receiving the data block.
	a_rd_phase: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res.rd_valid |-> state_q.phase == sdbt_pkg::PH_DATA)
		else $error("read byte delivered outside the data phase");

	// Payload bytes are consumed only during a write.
	a_take_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res.take_payload |-> state_q.is_write && res.tx_valid)
		else $error("payload taken outside a write");
`endif

endmodule
